// ===== hw/rtl/ipc_pkg.sv =====
// Shared types and constants for the clamped incremental PID core.
// Used by every module of the block; depends on nothing else.
package ipc_pkg;

	// Fixed-point format of the coefficients and of the stored output.
	localparam int FRAC_BITS = 16;

	// Field widths.
	localparam int COEF_W  = 32;
	localparam int ERR_W   = 16;
	localparam int DRIVE_W = 26;
	localparam int PROD_W  = COEF_W + ERR_W;
	localparam int ACC_W   = PROD_W + 2;

	// Clamp limit and output offset, both scaled to the fixed-point format.
	localparam longint unsigned UPPER_Q  = 64'd300 << FRAC_BITS;
	localparam longint unsigned OFFSET_Q = 64'd600 << FRAC_BITS;
	localparam int              LAST_W   = $clog2(UPPER_Q + 64'd1);

	// Drive values that each clamp produces.
	localparam logic [DRIVE_W-1:0] DRIVE_AT_ZERO  = DRIVE_W'(OFFSET_Q);
	localparam logic [DRIVE_W-1:0] DRIVE_AT_UPPER = DRIVE_W'(OFFSET_Q + UPPER_Q);

	// Configuration register map.
	localparam int REG_IDX_W = 2;
	localparam int ADDR_W    = REG_IDX_W + 2;
	localparam int DATA_W    = 32;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_COEF_CURRENT  = 2'd0,
		REG_COEF_PREVIOUS = 2'd1,
		REG_COEF_OLDER    = 2'd2
	} reg_idx_t;

	// Which limit the clamp applied.
	typedef enum logic [1:0] {
		LIMIT_NONE  = 2'd0,
		LIMIT_UPPER = 2'd1,
		LIMIT_ZERO  = 2'd2
	} limit_t;

	// Coefficient set handed from the register file to the datapath.
	typedef struct packed {
		logic signed [COEF_W-1:0] current;
		logic signed [COEF_W-1:0] previous;
		logic signed [COEF_W-1:0] older;
	} coef_t;

	// One result beat.
	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		limit_t             limit;
	} result_t;

endpackage

// ===== hw/rtl/ipc_regs.sv =====
// APB-style register file holding the three PID coefficients.
// Depends on ipc_pkg for the register map and the coefficient struct.
module ipc_regs
	import ipc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output coef_t             coef
);

	logic     wr_en;
	reg_idx_t idx;
	coef_t    coef_q;

	// Registers sit on word boundaries; the byte offset bits are ignored.
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign coef   = coef_q;

	// Coefficient registers; writes beyond the map are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_COEF_CURRENT:  coef_q.current  <= pwdata;
				REG_COEF_PREVIOUS: coef_q.previous <= pwdata;
				REG_COEF_OLDER:    coef_q.older    <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (idx)
			REG_COEF_CURRENT:  prdata = coef_q.current;
			REG_COEF_PREVIOUS: prdata = coef_q.previous;
			REG_COEF_OLDER:    prdata = coef_q.older;
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/ipc_calc.sv =====
// Velocity-form PID datapath: error history, stored clamped output and the
// multiply-accumulate-clamp logic. Depends on ipc_pkg.
module ipc_calc
	import ipc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  coef_t                   coef,
	input  logic signed [ERR_W-1:0] error_s1,
	input  logic                    advance,
	output result_t                 result
);

	logic signed [ERR_W-1:0]  last_error_q;
	logic signed [ERR_W-1:0]  older_error_q;
	logic        [LAST_W-1:0] last_output_q;

	logic signed [PROD_W-1:0] prod_cur;
	logic signed [PROD_W-1:0] prod_prev;
	logic signed [PROD_W-1:0] prod_old;
	logic signed [ACC_W-1:0]  acc;
	logic        [LAST_W-1:0] clamped;
	limit_t                   limit;

	// Three exact products, summed with the previous clamped output.
	assign prod_cur  = PROD_W'(coef.current)  * PROD_W'(error_s1);
	assign prod_prev = PROD_W'(coef.previous) * PROD_W'(last_error_q);
	assign prod_old  = PROD_W'(coef.older)    * PROD_W'(older_error_q);
	assign acc = ACC_W'(prod_cur) + ACC_W'(prod_prev) + ACC_W'(prod_old)
		+ $signed(ACC_W'(last_output_q));

	// Clamp to [0, upper]; landing exactly on a limit is not a clamp.
	always_comb begin
		if (acc[ACC_W-1]) begin
			clamped = '0;
			limit   = LIMIT_ZERO;
		end else if (acc[ACC_W-2:0] > (ACC_W-1)'(UPPER_Q)) begin
			clamped = LAST_W'(UPPER_Q);
			limit   = LIMIT_UPPER;
		end else begin
			clamped = acc[LAST_W-1:0];
			limit   = LIMIT_NONE;
		end
	end

	assign result.drive = DRIVE_W'(64'(clamped) + OFFSET_Q);
	assign result.limit = limit;

	// History advances with every beat that leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q  <= '0;
			older_error_q <= '0;
			last_output_q <= '0;
		end else if (advance) begin
			older_error_q <= last_error_q;
			last_error_q  <= error_s1;
			last_output_q <= clamped;
		end
	end

endmodule

// ===== hw/rtl/incremental_pid_clamped_core.sv =====
// Clamped incremental PID core: top level with input stage and output register.
// Depends on ipc_pkg, ipc_regs and ipc_calc.
//
// Takes one signed error beat per clock unless sample_stall is high and returns
// one drive beat per error beat through the input and result registers. The
// sustained rate is one beat per cycle while the output side does not stall:
// the three coefficient products, their sum with the stored clamped output
// and the clamp all sit in the single stage between the input and result
// registers, and that stage updates the error history and the stored output
// as each beat moves on. Coefficients sit at APB byte addresses 0, 4 and 8;
// write them only while no beat is in flight; the block does not enforce it.
module incremental_pid_clamped_core
	import ipc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// Configuration port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	// Error sample channel
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  logic signed [ERR_W-1:0] error_sample,
	// Drive channel
	output logic                    drive_valid,
	input  logic                    drive_stall,
	output logic [DRIVE_W-1:0]      drive_value,
	output logic [1:0]              limit_flag
);

	coef_t                   coef;
	logic                    valid_s1;
	logic signed [ERR_W-1:0] error_s1;
	logic                    advance;
	result_t                 result;
	logic                    drive_valid_q;
	result_t                 result_q;

	ipc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	ipc_calc u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef),
		.error_s1 (error_s1),
		.advance  (advance),
		.result   (result)
	);

	// A beat leaves the input stage when the result register is free or draining.
	assign advance      = valid_s1 && (!drive_valid_q || !drive_stall);
	assign sample_stall = valid_s1 && !advance;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sample_stall && sample_valid) begin
			error_s1 <= error_sample;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_valid_q <= 1'b0;
		end else if (advance) begin
			drive_valid_q <= 1'b1;
		end else if (!drive_stall) begin
			drive_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign drive_valid = drive_valid_q;
	assign drive_value = result_q.drive;
	assign limit_flag  = result_q.limit;

endmodule

// ===== hw/rtl/ipc_checker.sv =====
// Port-level checker for the clamped incremental PID core, with its bind.
// Depends on ipc_pkg and on the port list of incremental_pid_clamped_core.
module ipc_checker
	import ipc_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    sample_valid,
	input logic                    sample_stall,
	input logic signed [ERR_W-1:0] error_sample,
	input logic                    drive_valid,
	input logic                    drive_stall,
	input logic [DRIVE_W-1:0]      drive_value,
	input logic [1:0]              limit_flag
);

	// A clamp at the upper limit always shows the top drive value.
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && limit_flag == LIMIT_UPPER |-> drive_value == DRIVE_AT_UPPER)
		else $error("upper clamp with wrong drive value");

	// A clamp at zero always shows the bottom drive value.
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && limit_flag == LIMIT_ZERO |-> drive_value == DRIVE_AT_ZERO)
		else $error("zero clamp with wrong drive value");

	// Every drive beat lies between the two clamp values.
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> drive_value >= DRIVE_AT_ZERO && drive_value <= DRIVE_AT_UPPER)
		else $error("drive value out of range");

	// A stalled drive beat stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_stall |=>
			drive_valid && $stable(drive_value) && $stable(limit_flag))
		else $error("stalled drive beat changed");

	// A stalled error beat stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(error_sample))
		else $error("stalled error beat changed");

endmodule

bind incremental_pid_clamped_core ipc_checker u_ipc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.error_sample (error_sample),
	.drive_valid  (drive_valid),
	.drive_stall  (drive_stall),
	.drive_value  (drive_value),
	.limit_flag   (limit_flag)
);
